[hdl/eog_pkg.sv]
// shared types and constants for the elevation obstacle grid
`default_nettype none
package eog_pkg;
  localparam int MaxRowsDefault = 256;
  localparam int MaxColsDefault = 256;
  localparam logic signed [23:0] ElevMax = 24'sh7FFFFF;
  localparam logic [33:0] NormalThresh = 34'd26843546;
  localparam logic [7:0] ClassObstacle = 8'd255;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_GROUND = 2'd1,
    REQ_OBST   = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_EMPTY  = 2'd0,
    ST_GROUND = 2'd1,
    ST_OBST   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_INV_RES   = 3'd2,
    REG_CLIMB     = 3'd3,
    REG_HEIGHT    = 3'd4,
    REG_ROWS      = 3'd5,
    REG_COLS      = 3'd6,
    REG_UNKNOWN   = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL_X,
    S_MUL_Y,
    S_NORM_X,
    S_NORM_Y,
    S_NORM_Z,
    S_RD_WAIT,
    S_UPDATE,
    S_NB_ISSUE,
    S_NB_WAIT,
    S_RESULT
  } state_t;
endpackage
`default_nettype wire

[hdl/eog_mul.sv]
// shared signed multiplier with registered product
`default_nettype none
module eog_mul import eog_pkg::*; (
  input  wire                clk,
  input  wire signed [24:0]  a,
  input  wire signed [24:0]  b,
  output logic signed [49:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule
`default_nettype wire

[hdl/eog_store.sv]
// cell store: elevation and status memories, one port each
`default_nettype none
module eog_store import eog_pkg::*; #(
  parameter int Depth = MaxRowsDefault * MaxColsDefault,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire                clk,
  input  wire                we,
  input  wire [AddrW-1:0]    addr,
  input  wire signed [23:0]  wr_elev,
  input  status_t            wr_status,
  output logic signed [23:0] rd_elev,
  output status_t            rd_status
);
  logic signed [23:0] elev_mem [Depth];
  status_t            stat_mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      elev_mem[addr] <= wr_elev;
      stat_mem[addr] <= wr_status;
    end
    rd_elev   <= elev_mem[addr];
    rd_status <= stat_mem[addr];
  end
endmodule
`default_nettype wire

[hdl/elevation_obstacle_grid.sv]
// elevation obstacle grid top level: sequencer, config registers, store
//
// one request channel (req_valid/req_ready) carries clear, ground point,
// obstacle point and read requests; reads return one result on the
// cell_valid/cell_ready channel. the user must write config via cfg_we,
// cfg_index and cfg_data only while idle; the block does not enforce it.
// the block takes one request at a time through a shared 25x25 multiplier
// and a single-ported cell memory. the steps of each request, in order:
//   ground point: two binning products, memory read, update
//   obstacle point: three normal squares added first, then the ground steps
//   read: memory read; for an interior obstacle, eight neighbour reads,
//   each an issue and a wait state; the result is valid in RESULT after
//   RD_WAIT, UPDATE and any neighbour reads
//   clear: one pass over the store, writing every cell
// after reset the same clearing pass runs with req_ready low. a read result
// holds in its output register until cell_ready takes it; the next request
// is accepted after that transfer.
`default_nettype none
module elevation_obstacle_grid import eog_pkg::*; #(
  parameter int MaxRows = MaxRowsDefault,
  parameter int MaxCols = MaxColsDefault
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_we,
  input  wire [2:0]         cfg_index,
  input  wire [23:0]        cfg_data,
  input  wire               req_valid,
  output logic              req_ready,
  input  wire [1:0]         req_type,
  input  wire signed [23:0] point_x,
  input  wire signed [23:0] point_y,
  input  wire signed [23:0] point_z,
  input  wire signed [15:0] normal_x,
  input  wire signed [15:0] normal_y,
  input  wire signed [15:0] normal_z,
  input  wire [7:0]         cell_row,
  input  wire [7:0]         cell_col,
  output logic              cell_valid,
  input  wire               cell_ready,
  output logic [7:0]        cell_class,
  output logic              cell_in_range
);
  localparam int RowW  = $clog2(MaxRows);
  localparam int ColW  = $clog2(MaxCols);
  localparam int AddrW = RowW + ColW;
  localparam int Depth = 1 << AddrW;

  // config registers
  logic signed [23:0] origin_x, origin_y;
  logic [15:0] inv_resolution;
  logic [22:0] climb_step, height_limit;
  logic [8:0]  num_rows, num_cols;
  logic [7:0]  unknown_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0; origin_y <= '0; inv_resolution <= 16'd5120;
      climb_step <= 23'd410; height_limit <= 23'd2048;
      num_rows <= 9'd256; num_cols <= 9'd256; unknown_value <= 8'd127;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        REG_INV_RES:  inv_resolution <= cfg_data[15:0];
        REG_CLIMB:    climb_step <= cfg_data[22:0];
        REG_HEIGHT:   height_limit <= cfg_data[22:0];
        REG_ROWS:     num_rows <= cfg_data[8:0];
        REG_COLS:     num_cols <= cfg_data[8:0];
        REG_UNKNOWN:  unknown_value <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // effective grid size, saturated to the store
  logic [12:0] rows_eff, cols_eff;
  always_comb begin
    rows_eff = (13'(num_rows) > 13'(MaxRows)) ? 13'(MaxRows) : 13'(num_rows);
    cols_eff = (13'(num_cols) > 13'(MaxCols)) ? 13'(MaxCols) : 13'(num_cols);
  end

  // captured request
  req_t               req;
  logic signed [23:0] px, py, pz;
  logic signed [15:0] nx, ny, nz;
  logic [7:0]         rrow, rcol;

  state_t state, state_next;
  logic [AddrW:0]  clr_cnt;
  logic [33:0]     norm_acc;
  logic [12:0]     col_bin;
  logic            col_ok;
  logic [2:0]      nb_idx;
  logic            nb_any;
  logic [7:0]      res_class;
  logic            res_range;

  // shared multiplier operand select
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] mul_p;
  always_comb begin
    case (state)
      S_MUL_X: begin mul_a = 25'(px) - 25'(origin_x); mul_b = 25'($signed({1'b0, inv_resolution})); end
      S_MUL_Y: begin mul_a = 25'(py) - 25'(origin_y); mul_b = 25'($signed({1'b0, inv_resolution})); end
      S_NORM_X: begin mul_a = 25'(nx); mul_b = 25'(nx); end
      S_NORM_Y: begin mul_a = 25'(ny); mul_b = 25'(ny); end
      S_NORM_Z: begin mul_a = 25'(nz); mul_b = 25'(nz); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  eog_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  // truncate toward zero, range check against size
  logic [29:0] bin_mag;
  logic        bin_ok;
  logic [12:0] bin_val;
  logic [12:0] bin_lim;
  always_comb begin
    bin_lim = (state == S_MUL_Y || state == S_NORM_X) ? cols_eff : rows_eff;
    if (mul_p < 0) begin
      bin_mag = 30'((-mul_p) >>> 20);
      bin_ok  = (bin_mag == '0) && (bin_lim != 13'd0);
    end else begin
      bin_mag = 30'(mul_p >>> 20);
      bin_ok  = (bin_mag < 30'(bin_lim));
    end
    bin_val = bin_mag[12:0];
  end

  // store port
  logic                mem_we;
  logic [AddrW-1:0]    mem_addr;
  logic signed [23:0]  mem_wr_elev;
  status_t             mem_wr_status;
  logic signed [23:0]  rd_elev;
  status_t             rd_status;
  logic [AddrW-1:0]    cell_addr;
  logic [12:0]         row_bin;

  eog_store #(.Depth(Depth), .AddrW(AddrW)) u_store (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wr_elev(mem_wr_elev),
    .wr_status(mem_wr_status), .rd_elev(rd_elev), .rd_status(rd_status)
  );

  // neighbour offset for the current neighbour index
  logic signed [1:0] dr, dc;
  always_comb begin
    case (nb_idx)
      3'd0: begin dr = -2'sd1; dc = -2'sd1; end
      3'd1: begin dr = -2'sd1; dc =  2'sd0; end
      3'd2: begin dr = -2'sd1; dc =  2'sd1; end
      3'd3: begin dr =  2'sd0; dc = -2'sd1; end
      3'd4: begin dr =  2'sd0; dc =  2'sd1; end
      3'd5: begin dr =  2'sd1; dc = -2'sd1; end
      3'd6: begin dr =  2'sd1; dc =  2'sd0; end
      default: begin dr = 2'sd1; dc = 2'sd1; end
    endcase
  end

  logic read_in, interior;
  logic [12:0] nb_r, nb_c;
  always_comb begin
    read_in  = (13'(rrow) < rows_eff) && (13'(rcol) < cols_eff);
    interior = (rrow != 8'd0) && (rcol != 8'd0) &&
               (13'(rrow) < rows_eff - 13'd1) && (13'(rcol) < cols_eff - 13'd1);
    nb_r = 13'(rrow) + 13'(dr);
    nb_c = 13'(rcol) + 13'(dc);
  end

  // band check for obstacle points
  logic signed [25:0] lo_b, hi_b;
  logic obst_hit;
  always_comb begin
    lo_b = 26'(rd_elev) + 26'($signed({1'b0, climb_step}));
    hi_b = 26'(rd_elev) + 26'($signed({1'b0, height_limit}));
    obst_hit = (rd_status != ST_EMPTY) && (26'(pz) >= lo_b) && (26'(pz) <= hi_b);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == (AddrW+1)'(Depth - 1)) state_next = S_IDLE;
      S_IDLE: if (req_valid) begin
        case (req_t'(req_type))
          REQ_CLEAR:  state_next = S_CLEAR;
          REQ_GROUND: state_next = S_MUL_X;
          REQ_OBST:   state_next = S_NORM_X;
          default:    state_next = S_RD_WAIT;
        endcase
      end
      S_NORM_X: state_next = S_NORM_Y;
      S_NORM_Y: state_next = S_NORM_Z;
      S_NORM_Z: state_next = S_MUL_X;
      S_MUL_X: state_next = S_MUL_Y;
      S_MUL_Y: state_next = S_RD_WAIT;
      S_RD_WAIT: state_next = S_UPDATE;
      S_UPDATE: begin
        if (req != REQ_READ) state_next = S_IDLE;
        else if (read_in && rd_status == ST_OBST && interior) state_next = S_NB_ISSUE;
        else state_next = S_RESULT;
      end
      S_NB_ISSUE: state_next = S_NB_WAIT;
      S_NB_WAIT: state_next = (nb_idx == 3'd7) ? S_RESULT : S_NB_ISSUE;
      S_RESULT: if (cell_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and store control
  logic point_ok;
  always_comb begin
    req_ready     = (state == S_IDLE);
    cell_valid    = (state == S_RESULT);
    cell_class    = res_class;
    cell_in_range = res_range;
    point_ok      = col_ok && (norm_acc >= NormalThresh || req == REQ_GROUND);
    mem_we        = 1'b0;
    mem_wr_elev   = ElevMax;
    mem_wr_status = ST_EMPTY;
    cell_addr     = {row_bin[RowW-1:0], col_bin[ColW-1:0]};
    case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt[AddrW-1:0];
      end
      S_RD_WAIT, S_UPDATE: begin
        // the row product is still on the multiplier output during the read
        if (req == REQ_READ) mem_addr = {RowW'(rrow), ColW'(rcol)};
        else if (state == S_RD_WAIT) mem_addr = {bin_val[RowW-1:0], col_bin[ColW-1:0]};
        else mem_addr = cell_addr;
        if (state == S_UPDATE && req != REQ_READ && point_ok) begin
          if (req == REQ_GROUND) begin
            if (rd_status == ST_EMPTY || pz < rd_elev) begin
              mem_we = 1'b1; mem_wr_elev = pz; mem_wr_status = ST_GROUND;
            end
          end else if (obst_hit) begin
            mem_we = 1'b1; mem_wr_elev = pz; mem_wr_status = ST_OBST;
          end
        end
      end
      S_NB_ISSUE, S_NB_WAIT: mem_addr = {nb_r[RowW-1:0], nb_c[ColW-1:0]};
      default: mem_addr = cell_addr;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      else clr_cnt <= '0;
    end
    if (state == S_IDLE && req_valid) begin
      req <= req_t'(req_type);
      px <= point_x; py <= point_y; pz <= point_z;
      nx <= normal_x; ny <= normal_y; nz <= normal_z;
      rrow <= cell_row; rcol <= cell_col;
      norm_acc <= '0;
    end
    // products are registered and arrive in the state after their operand state
    case (state)
      S_NORM_Y, S_NORM_Z, S_MUL_X: if (req == REQ_OBST) norm_acc <= norm_acc + 34'(mul_p);
      S_MUL_Y: begin col_bin <= bin_val; col_ok <= bin_ok; end
      S_RD_WAIT: if (req != REQ_READ) begin
        row_bin <= bin_val; col_ok <= col_ok && bin_ok;
      end
      default: ;
    endcase
    if (state == S_UPDATE) begin
      nb_idx    <= '0;
      nb_any    <= 1'b0;
      res_range <= read_in;
      if (!read_in) res_class <= 8'd0;
      else if (rd_status == ST_EMPTY) res_class <= unknown_value;
      else if (rd_status == ST_OBST) res_class <= ClassObstacle;
      else res_class <= 8'd0;
    end
    if (state == S_NB_WAIT) begin
      nb_idx <= nb_idx + 3'd1;
      if (nb_idx == 3'd7) res_class <= (nb_any || rd_status == ST_OBST) ? ClassObstacle : 8'd0;
      else nb_any <= nb_any || (rd_status == ST_OBST);
    end
  end
endmodule
`default_nettype wire

[tb/elevation_obstacle_grid_tb.sv]
// testbench for the elevation obstacle grid: directed and random requests vs. a cell-store model
`timescale 1ns / 1ps
module elevation_obstacle_grid_tb import eog_pkg::*;;

  localparam int NCells = 256 * 256;
  localparam int CycleLimit = 8000000;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [7:0]         row;
    logic [7:0]         col;
  } grid_req_t;

  typedef struct packed {
    logic [7:0] cls;
    logic       in_range;
  } cell_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_ready;
  logic [1:0] req_type = '0;
  logic signed [23:0] point_x = '0, point_y = '0, point_z = '0;
  logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic [7:0] cell_row = '0, cell_col = '0;
  logic cell_valid;
  logic cell_ready = 1'b0;
  logic [7:0] cell_class;
  logic cell_in_range;

  elevation_obstacle_grid u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .cell_row(cell_row), .cell_col(cell_col), .cell_valid(cell_valid),
    .cell_ready(cell_ready), .cell_class(cell_class), .cell_in_range(cell_in_range)
  );

  // model state
  logic signed [23:0] m_org_x, m_org_y;
  logic [15:0] m_inv_res;
  logic [22:0] m_climb, m_height;
  logic [8:0] m_rows, m_cols;
  logic [7:0] m_unknown;
  logic signed [23:0] m_elev [NCells];
  status_t m_stat [NCells];

  grid_req_t pending_reqs[$];
  cell_res_t expected_cells[$];
  int mismatches = 0;
  int cycles = 0;
  bit no_idle = 1'b0;
  bit hold_off = 1'b0;
  int sent = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic clear_model();
    for (int i = 0; i < NCells; i++) begin
      m_elev[i] = ElevMax;
      m_stat[i] = ST_EMPTY;
    end
  endtask

  function automatic int bin_axis(logic signed [23:0] p, logic signed [23:0] org, int lim);
    longint prod;
    longint q;
    prod = (longint'(p) - longint'(org)) * longint'(m_inv_res);
    q = prod >= 0 ? (prod >>> 20) : -((-prod) >>> 20);
    if (q < 0 || q >= lim) return -1;
    return int'(q);
  endfunction

  function automatic int eff_size(logic [8:0] n);
    return n > 256 ? 256 : int'(n);
  endfunction

  function automatic int hit_cell(grid_req_t r);
    int c;
    int rr;
    c = bin_axis(r.px, m_org_x, eff_size(m_cols));
    rr = bin_axis(r.py, m_org_y, eff_size(m_rows));
    if (c < 0 || rr < 0) return -1;
    return rr * 256 + c;
  endfunction

  // applies one request to the model; pushes a result for reads
  task automatic apply_request(grid_req_t r);
    int a;
    int rows;
    int cols;
    longint g;
    longint nrm;
    bit any;
    cell_res_t res;
    rows = eff_size(m_rows);
    cols = eff_size(m_cols);
    case (req_t'(r.kind))
      REQ_CLEAR: clear_model();
      REQ_GROUND: begin
        a = hit_cell(r);
        if (a >= 0 && (m_stat[a] == ST_EMPTY || r.pz < m_elev[a])) begin
          m_elev[a] = r.pz;
          m_stat[a] = ST_GROUND;
        end
      end
      REQ_OBST: begin
        nrm = longint'(r.nx) * r.nx + longint'(r.ny) * r.ny + longint'(r.nz) * r.nz;
        a = hit_cell(r);
        if (nrm >= longint'(NormalThresh) && a >= 0 && m_stat[a] != ST_EMPTY) begin
          g = m_elev[a];
          if (longint'(r.pz) >= g + longint'(m_climb) &&
              longint'(r.pz) <= g + longint'(m_height)) begin
            m_stat[a] = ST_OBST;
            m_elev[a] = r.pz;
          end
        end
      end
      default: begin
        if (r.row >= rows || r.col >= cols) begin
          res = '{cls: 8'd0, in_range: 1'b0};
        end else begin
          a = r.row * 256 + r.col;
          res.in_range = 1'b1;
          if (m_stat[a] == ST_EMPTY) res.cls = m_unknown;
          else if (m_stat[a] == ST_OBST) begin
            res.cls = ClassObstacle;
            if (r.row >= 1 && r.row < rows - 1 && r.col >= 1 && r.col < cols - 1) begin
              any = 1'b0;
              for (int dr = -1; dr <= 1; dr++)
                for (int dc = -1; dc <= 1; dc++)
                  if (!(dr == 0 && dc == 0) && m_stat[a + dr * 256 + dc] == ST_OBST) any = 1'b1;
              if (!any) res.cls = 8'd0;
            end
          end else res.cls = 8'd0;
        end
        expected_cells.push_back(res);
      end
    endcase
  endtask

  // sender
  int send_gap = 0;
  logic req_taken = 1'b0;
  always @(posedge clk) begin
    req_taken <= !rst && req_valid && req_ready;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (req_valid && req_taken) begin
        sent <= sent + 1;
        apply_request(pending_reqs.pop_front());
      end
      if (!(req_valid && !req_taken)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !(!no_idle && $urandom_range(0, 7) == 0)) begin
          req_valid <= 1'b1;
          req_type <= pending_reqs[0].kind;
          point_x <= pending_reqs[0].px;
          point_y <= pending_reqs[0].py;
          point_z <= pending_reqs[0].pz;
          normal_x <= pending_reqs[0].nx;
          normal_y <= pending_reqs[0].ny;
          normal_z <= pending_reqs[0].nz;
          cell_row <= pending_reqs[0].row;
          cell_col <= pending_reqs[0].col;
        end else begin
          req_valid <= 1'b0;
          if (!no_idle && pending_reqs.size() > 0) send_gap <= $urandom_range(0, 15);
        end
      end
    end
  end

  // receiver
  int recv_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_off || recv_gap > 0) begin
        cell_ready <= 1'b0;
        if (recv_gap > 0) recv_gap <= recv_gap - 1;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        cell_ready <= 1'b0;
        recv_gap <= $urandom_range(0, 15);
      end else cell_ready <= 1'b1;
    end
  end

  // checker
  always @(posedge clk) begin
    cell_res_t want;
    if (!rst && cell_valid && cell_ready) begin
      if (expected_cells.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected cell transfer: class %0d", cell_class);
      end else begin
        want = expected_cells.pop_front();
        if (want.cls !== cell_class || want.in_range !== cell_in_range) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("cell mismatch: expected class %0d in_range %0b, got %0d %0b",
                     want.cls, want.in_range, cell_class, cell_in_range);
        end
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ORIGIN_X: m_org_x = val;
      REG_ORIGIN_Y: m_org_y = val;
      REG_INV_RES:  m_inv_res = val[15:0];
      REG_CLIMB:    m_climb = val[22:0];
      REG_HEIGHT:   m_height = val[22:0];
      REG_ROWS:     m_rows = val[8:0];
      REG_COLS:     m_cols = val[8:0];
      default:      m_unknown = val[7:0];
    endcase
  endtask

  // waits until queues drain and the block has finished its last request
  task automatic drain();
    while (pending_reqs.size() > 0 || req_valid || expected_cells.size() > 0) @(posedge clk);
    repeat (NCells + 100) @(posedge clk);
  endtask

  function automatic grid_req_t rand_req(int cell_span, int z_base);
    grid_req_t r;
    int k;
    r = '0;
    k = $urandom_range(0, 99);
    r.kind = k < 1 ? REQ_CLEAR : (k < 40 ? REQ_GROUND : (k < 70 ? REQ_OBST : REQ_READ));
    if ($urandom_range(0, 9) == 0) begin
      r.px = 24'($urandom); r.py = 24'($urandom); r.pz = 24'($urandom);
      r.nx = 16'($urandom); r.ny = 16'($urandom); r.nz = 16'($urandom);
    end else begin
      // points aimed at a small block of cells so obstacles cluster
      r.px = 24'(m_org_x + ($urandom_range(0, cell_span) << 20) /
                 (m_inv_res == 0 ? 1 : m_inv_res) + $urandom_range(0, 3));
      r.py = 24'(m_org_y + ($urandom_range(0, cell_span) << 20) /
                 (m_inv_res == 0 ? 1 : m_inv_res) + $urandom_range(0, 3));
      r.pz = 24'(z_base + int'($urandom_range(0, 3000)) - 500);
      r.nx = 16'(int'($urandom_range(0, 20000)) - 10000);
      r.ny = 16'(int'($urandom_range(0, 20000)) - 10000);
      r.nz = 16'(int'($urandom_range(0, 20000)) - 10000);
    end
    r.row = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, cell_span + 1));
    r.col = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, cell_span + 1));
    return r;
  endfunction

  function automatic grid_req_t mk(req_t k, int x, int y, int z, int n, int r, int c);
    grid_req_t q;
    q = '{kind: k, px: 24'(x), py: 24'(y), pz: 24'(z), nx: 16'(n), ny: 16'd0, nz: 16'd0,
          row: 8'(r), col: 8'(c)};
    return q;
  endfunction

  initial begin
    m_org_x = 0; m_org_y = 0; m_inv_res = 5120; m_climb = 410; m_height = 2048;
    m_rows = 256; m_cols = 256; m_unknown = 127;
    clear_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (NCells + 100) @(posedge clk);

    // directed: extremes, every request kind, isolated and clustered obstacles
    pending_reqs.push_back(mk(REQ_READ, 0, 0, 0, 0, 255, 255));
    pending_reqs.push_back(mk(REQ_GROUND, 24'h7FFFFF, 24'h7FFFFF, -8388608, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_GROUND, -8388608, -8388608, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_GROUND, 5000, 5000, 100, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_GROUND, 5000, 5000, 50, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_OBST, 5000, 5000, 500, 5000, 0, 0));
    pending_reqs.push_back(mk(REQ_OBST, 5000, 5000, 900, 16384, 0, 0));
    pending_reqs.push_back(mk(REQ_READ, 0, 0, 0, 0, 24, 24));
    pending_reqs.push_back(mk(REQ_GROUND, 5300, 5000, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_OBST, 5300, 5000, 2048, -32768, 0, 0));
    pending_reqs.push_back(mk(REQ_READ, 0, 0, 0, 0, 24, 24));
    pending_reqs.push_back(mk(REQ_READ, 0, 0, 0, 0, 24, 25));
    pending_reqs.push_back(mk(REQ_OBST, 8000, 8000, 100, 16384, 0, 0));
    pending_reqs.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_READ, 0, 0, 0, 0, 24, 24));
    // receiver holds off while requests keep coming
    for (int i = 0; i < 6; i++) pending_reqs.push_back(mk(REQ_READ, 0, 0, 0, 0, i, i));
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
    drain();

    // phases over several settings, extremes included
    for (int ph = 0; ph < 9; ph++) begin
      int span;
      int zb;
      case (ph)
        0: begin write_reg(REG_ROWS, 9'd8); write_reg(REG_COLS, 9'd8); end
        1: begin write_reg(REG_ORIGIN_X, -24'sd40000); write_reg(REG_ORIGIN_Y, 24'd30000);
                 write_reg(REG_UNKNOWN, 8'd0); write_reg(REG_CLIMB, 23'd0);
                 write_reg(REG_HEIGHT, 23'h7FFFFF); end
        2: begin write_reg(REG_ROWS, 9'd2); write_reg(REG_COLS, 9'd1);
                 write_reg(REG_UNKNOWN, 8'd255); end
        3: begin write_reg(REG_ROWS, 9'd511); write_reg(REG_COLS, 9'd0);
                 write_reg(REG_INV_RES, 16'hFFFF); end
        4: begin write_reg(REG_ROWS, 9'd3); write_reg(REG_COLS, 9'd3);
                 write_reg(REG_INV_RES, 16'd1); write_reg(REG_ORIGIN_X, 24'h800000);
                 write_reg(REG_ORIGIN_Y, 24'h7FFFFF); end
        5: begin write_reg(REG_ROWS, 9'd256); write_reg(REG_COLS, 9'd256);
                 write_reg(REG_INV_RES, 16'd0); write_reg(REG_CLIMB, 23'h7FFFFF);
                 write_reg(REG_HEIGHT, 23'd0); end
        6: begin write_reg(REG_INV_RES, 16'd2560); write_reg(REG_ORIGIN_X, 24'd0);
                 write_reg(REG_ORIGIN_Y, 24'd0); write_reg(REG_CLIMB, 23'd200);
                 write_reg(REG_HEIGHT, 23'd3000); write_reg(REG_ROWS, 9'd12);
                 write_reg(REG_COLS, 9'd7); write_reg(REG_UNKNOWN, 8'd127); end
        7: begin write_reg(REG_ORIGIN_X, -24'sd100); write_reg(REG_ORIGIN_Y, -24'sd100); end
        default: no_idle = 1'b1;
      endcase
      span = 10;
      zb = int'($urandom_range(0, 4000)) - 2000;
      for (int i = 0; i < 150; i++) pending_reqs.push_back(rand_req(span, zb));
      drain();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[files.f]
hdl/eog_pkg.sv
hdl/eog_mul.sv
hdl/eog_store.sv
hdl/elevation_obstacle_grid.sv
tb/elevation_obstacle_grid_tb.sv
